@@ hw/rtl/sngr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sngr_pkg
// Shared types, constants and the glyph font for the number renderer.
// ---------------------------------------------------------------------------
package sngr_pkg;

    localparam int SCREEN_WIDTH_DEF = 128;
    localparam int PAGE_COUNT_DEF   = 8;
    localparam int FIELD_CHARS_DEF  = 12;

    localparam logic [1:0] KIND_POS    = 2'd0;
    localparam logic [1:0] KIND_GLYPH  = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    localparam logic [3:0] SYM_MINUS = 4'd10;
    localparam logic [3:0] SYM_SPACE = 4'd11;
    localparam logic [7:0] CMD_PAGE  = 8'hB0;
    localparam logic [7:0] CMD_COLHI = 8'h10;
    localparam int         GLYPH_COLS = 6;

    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         min_width;
        logic [7:0]         x_column;
        logic [7:0]         page_row;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [47:0] payload;
        logic        rejected;
        logic        last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input beat
        logic div_step;  // one divide-by-ten step
        logic emit;      // advance to the next result
    } sngr_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic reject;
        logic div_done;
        logic none_fit;
        logic last_out;
    } sngr_sts_t;

    function automatic logic [47:0] glyph(input logic [3:0] sym);
        logic [47:0] g;
        case (sym)
            4'd0:    g = 48'h3E_45_49_51_3E_00;
            4'd1:    g = 48'h00_40_7F_42_00_00;
            4'd2:    g = 48'h46_49_51_61_42_00;
            4'd3:    g = 48'h31_4B_45_41_21_00;
            4'd4:    g = 48'h10_7F_12_14_18_00;
            4'd5:    g = 48'h39_45_45_45_27_00;
            4'd6:    g = 48'h30_49_49_4A_3C_00;
            4'd7:    g = 48'h03_05_09_71_01_00;
            4'd8:    g = 48'h36_49_49_49_36_00;
            4'd9:    g = 48'h1E_29_49_49_06_00;
            4'd10:   g = 48'h08_08_08_08_08_00;
            default: g = 48'h0;
        endcase
        return g;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/signed_number_glyph_renderer_core.sv @@
// Signed number glyph renderer.
// in  : valid/ready beat of {value, min_width, x_column, page_row}.
// out : valid/ready beats of {kind, payload, rejected, last}; last marks the
//       final beat of an input. A valid position with room for a glyph gives
//       one position beat then one beat per glyph; otherwise a single status beat.
// Sequence: the input is captured, then one divide-by-ten step per decimal digit
// (1 to 10 digits, single reciprocal multiplier; skipped for a rejected
// position), then the divide finish is seen, then one beat per cycle while
// out_ready is high. The next input is taken once the last beat is accepted.
// Reset returns the sequencer to idle with no beat pending. A stalled
// receiver holds the current beat steady until it is taken.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// signed_number_glyph_renderer_core
// Top level: sequencer plus datapath.
// ---------------------------------------------------------------------------
module signed_number_glyph_renderer_core
    import sngr_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int PAGE_COUNT   = PAGE_COUNT_DEF,
    parameter int FIELD_CHARS  = FIELD_CHARS_DEF
)
(
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  wire       out_ready,
    output out_item_t out_data
);
    sngr_cmd_t cmd;
    sngr_sts_t sts;

    sngr_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .cmd(cmd), .sts(sts)
    );

    sngr_datapath #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .PAGE_COUNT(PAGE_COUNT), .FIELD_CHARS(FIELD_CHARS)
    ) u_dp (
        .clk(clk), .in_item(in_data), .cmd(cmd), .sts(sts), .out_item(out_data)
    );
endmodule
`default_nettype wire

@@ hw/rtl/sngr_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sngr_ctrl
// Sequencer: accept, digit extraction, result emission.
// ---------------------------------------------------------------------------
module sngr_ctrl
    import sngr_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  wire        out_ready,
    output sngr_cmd_t  cmd,
    input  sngr_sts_t  sts
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        out_valid    = 1'b0;
        cmd          = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.reject || sts.div_done)
                    state_next = S_OUT;
                else
                    cmd.div_step = 1'b1;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.emit = 1'b1;
                    if (sts.reject || sts.none_fit || sts.last_out)
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ hw/rtl/sngr_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sngr_datapath
// Magnitude divider, digit store, text indexing and glyph lookup.
// ---------------------------------------------------------------------------
module sngr_datapath
    import sngr_pkg::*;
#(
    parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF,
    parameter int PAGE_COUNT   = PAGE_COUNT_DEF,
    parameter int FIELD_CHARS  = FIELD_CHARS_DEF
)
(
    input  wire        clk,
    input  in_item_t   in_item,
    input  sngr_cmd_t  cmd,
    output sngr_sts_t  sts,
    output out_item_t  out_item
);
    localparam int CW = $clog2(FIELD_CHARS + 12);

    logic [31:0] mag_reg;
    logic [3:0]  dig_reg [10];
    logic [3:0]  nd_reg;
    logic        neg_reg;
    logic [7:0]  x_reg, page_reg, minw_reg;
    logic        rej_reg;
    logic [CW-1:0] idx_reg;   // 0 = position beat, i = glyph i-1

    // mag/10 by reciprocal: floor(m*0xCCCCCCCD >> 35), exact for 32-bit m
    logic [63:0] prod;
    logic [31:0] q;
    logic [3:0]  r;
    assign prod = {32'd0, mag_reg} * 64'h0000_0000_CCCC_CCCD;
    assign q    = {3'd0, prod[63:35]};
    assign r    = 4'(mag_reg - q * 32'd10);

    logic [4:0]  want, core, pad, len;
    logic [8:0]  room;
    logic [16:0] fit_prod;
    logic [7:0]  fit;
    logic [CW-1:0] n;
    assign want = (minw_reg > 8'(FIELD_CHARS)) ? 5'(FIELD_CHARS) : minw_reg[4:0];
    assign core = {1'b0, nd_reg} + {4'd0, neg_reg};
    assign pad  = (want > core) ? want - core : 5'd0;
    assign len  = pad + core;
    assign room = 9'(SCREEN_WIDTH) - {1'b0, x_reg};
    // room/6 as room*171 >> 10, exact for room up to 256
    assign fit_prod = {8'd0, room} * 17'd171;
    assign fit  = {1'b0, fit_prod[16:10]};
    assign n    = ({3'd0, len} < fit) ? CW'(len) : CW'(fit);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_reg  <= in_item.value[31] ? 32'(-in_item.value) : in_item.value;
            neg_reg  <= in_item.value[31];
            x_reg    <= in_item.x_column;
            page_reg <= in_item.page_row;
            minw_reg <= in_item.min_width;
            rej_reg  <= ({1'b0, in_item.x_column} >= 9'(SCREEN_WIDTH))
                     || ({1'b0, in_item.page_row} >= 9'(PAGE_COUNT));
            nd_reg   <= 4'd0;
            idx_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            dig_reg[nd_reg] <= r;
            mag_reg <= q;
            nd_reg  <= nd_reg + 4'd1;
        end
        else if (cmd.emit)
            idx_reg <= idx_reg + 1'b1;
    end

    logic [CW-1:0] pos;
    logic [3:0]    sym, di;
    assign pos = idx_reg - 1'b1;
    assign di  = 4'(nd_reg - 4'd1 - 4'(pos - CW'(pad) - CW'(neg_reg)));
    always_comb
    begin
        if (pos < CW'(pad))
            sym = SYM_SPACE;
        else if (neg_reg && pos == CW'(pad))
            sym = SYM_MINUS;
        else
            sym = dig_reg[di];
    end

    assign sts.reject   = rej_reg;
    assign sts.div_done = (nd_reg != 4'd0) && (mag_reg == 32'd0 || nd_reg == 4'd10);
    assign sts.none_fit = (n == '0);
    assign sts.last_out = (idx_reg == n);

    always_comb
    begin
        out_item = '0;
        if (rej_reg || n == '0)
        begin
            out_item.kind     = KIND_STATUS;
            out_item.rejected = rej_reg;
            out_item.last     = 1'b1;
        end
        else if (idx_reg == '0)
        begin
            out_item.kind    = KIND_POS;
            out_item.payload = {24'd0, 4'd0, x_reg[3:0], CMD_COLHI | {4'd0, x_reg[7:4]},
                                CMD_PAGE + page_reg};
        end
        else
        begin
            out_item.kind    = KIND_GLYPH;
            out_item.payload = glyph(sym);
            out_item.last    = (idx_reg == n);
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/sngr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// sngr_checker
// Port-level checks, bound to the top level.
// ---------------------------------------------------------------------------
module sngr_checker
    import sngr_pkg::*;
(
    input wire       clk,
    input wire       rst_n,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input out_item_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("beat changed under stall");
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input taken while output pending");
    a_stat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_STATUS |-> out_data.last)
        else $error("status beat without last");
    a_rej: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.rejected |-> out_data.kind == KIND_STATUS)
        else $error("reject on data beat");
endmodule

bind signed_number_glyph_renderer_core sngr_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
    .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire
